FILE: hw/rtl/llss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// llss_pkg
// Shared types, constants and helpers for the least loaded slot selector.
// ----------------------------------------------------------------------------
package llss_pkg;

  localparam int MAX_SLOTS  = 16;
  localparam int LOAD_WIDTH = 16;
  localparam int IDX_W      = $clog2(MAX_SLOTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int POOL_W     = 5;
  localparam int CMD_W      = 2;

  typedef logic [LOAD_WIDTH-1:0] load_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [POOL_W-1:0]     pool_t;
  typedef logic [CMD_W-1:0]      cmd_t;

  localparam load_t LOAD_MAX = {LOAD_WIDTH{1'b1}};

  localparam cmd_t CMD_NEXT    = 2'd0;
  localparam cmd_t CMD_ACQUIRE = 2'd1;
  localparam cmd_t CMD_RELEASE = 2'd2;

  // request from the sequencer to the load memory
  typedef struct packed {
    idx_t  rd_addr;
    logic  we;
    idx_t  wr_addr;
    load_t wr_data;
  } mem_req_t;

  // zero counts as one slot, anything past the table as the full table
  function automatic cnt_t eff_size(input pool_t pool);
    cnt_t n;
    if (pool == '0) begin
      n = cnt_t'(1);
    end else if (pool > pool_t'(MAX_SLOTS)) begin
      n = cnt_t'(MAX_SLOTS);
    end else begin
      n = cnt_t'(pool);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/llss_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// llss_in_if
// Command channel: valid/ready handshake with command and release slot.
// ----------------------------------------------------------------------------
interface llss_in_if
  import llss_pkg::*;
();
  logic valid;
  logic ready;
  cmd_t cmd;
  idx_t release_index;

  modport source (output valid, output cmd, output release_index, input ready);
  modport sink   (input valid, input cmd, input release_index, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/llss_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// llss_out_if
// Result channel: valid/ready handshake with chosen slot, its load and flag.
// ----------------------------------------------------------------------------
interface llss_out_if
  import llss_pkg::*;
();
  logic  valid;
  logic  ready;
  idx_t  chosen_index;
  load_t chosen_load;
  logic  ignored;

  modport source (output valid, output chosen_index, output chosen_load,
                  output ignored, input ready);
  modport sink   (input valid, input chosen_index, input chosen_load,
                  input ignored, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/least_loaded_slot_selector_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// least_loaded_slot_selector_top
// Worker-slot dispatcher: round-robin pointer plus least-loaded selection.
//
// in_ch carries one command per transaction: next (returns the round-robin
// slot and advances it), acquire (returns the lowest-indexed least loaded
// slot and bumps its load, saturating) or release (drops the named slot's
// load, not below zero; a slot outside the pool sets ignored). out_ch
// returns exactly one result transaction per command.
// The pool size register is written through cfg_we / cfg_wdata; the user must
// write it only while idle, as the block itself does not enforce it.
// Next and release read the load memory before the result register is set,
// the unused code and an ignored release set it directly, and acquire first
// scans the pool, since the single compare unit sees one load counter per
// memory read cycle. in_ch is ready again only after the result goes into
// the output register, so no command is taken before the last one is done.
// When out_ch stalls the finished result waits in the sequencer until the
// output register frees up; in_ch stays not ready meanwhile.
// Reset clears all loads, the pointer and sets the pool size to one.
// ----------------------------------------------------------------------------
module least_loaded_slot_selector_top
  import llss_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_we,
  input  wire pool_t cfg_wdata,
  llss_in_if.sink    in_ch,
  llss_out_if.source out_ch
);

  pool_t    pool_size;
  cnt_t     n_size;
  mem_req_t mem_req;
  load_t    rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size <= pool_t'(1);
    end else if (cfg_we) begin
      pool_size <= cfg_wdata;
    end
  end

  assign n_size = eff_size(pool_size);

  llss_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .n_size  (n_size),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  llss_load_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .req     (mem_req),
    .rd_data (rd_data)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/llss_load_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// llss_load_mem
// Per-slot load counters: one write and one registered read port per cycle,
// with a valid bit per entry so that reset reads back as zero load.
// ----------------------------------------------------------------------------
module llss_load_mem
  import llss_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire mem_req_t req,
  output load_t         rd_data
);

  load_t                mem [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] valid;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data <= valid[req.rd_addr] ? mem[req.rd_addr] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.we) begin
      valid[req.wr_addr] <= 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/llss_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// llss_ctrl
// Command sequencer: walks the load memory one slot a cycle through a single
// compare and increment/decrement unit, and holds the result register.
// ----------------------------------------------------------------------------
module llss_ctrl
  import llss_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cnt_t  n_size,
  llss_in_if.sink    in_ch,
  llss_out_if.source out_ch,
  output mem_req_t   mem_req,
  input  wire load_t rd_data
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_NEXT_RD = 3'd1;
  localparam logic [2:0] S_SCAN    = 3'd2;
  localparam logic [2:0] S_ACQ_WR  = 3'd3;
  localparam logic [2:0] S_REL_RD  = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  logic [2:0] state;
  cnt_t       n_q;
  idx_t       rr_ptr;
  cnt_t       scan_cnt;
  idx_t       cmp_idx;
  idx_t       best_idx;
  load_t      best_load;
  idx_t       res_index;
  load_t      res_load;
  logic       res_ign;
  logic       out_valid;
  idx_t       out_index;
  load_t      out_load;
  logic       out_ign;

  logic  accept;
  idx_t  ptr_eff;
  cnt_t  ptr_inc;
  logic  unit_lt;
  load_t unit_a;
  load_t unit_inc;
  load_t unit_dec;
  logic  out_free;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid || out_ch.ready;

  // pointer left behind by a shrunk pool restarts at slot 0
  assign ptr_eff = (cnt_t'(rr_ptr) >= n_size) ? '0 : rr_ptr;
  assign ptr_inc = cnt_t'(cmp_idx) + cnt_t'(1);

  // shared compare / saturating increment / saturating decrement unit
  always_comb begin
    unit_a   = (state == S_ACQ_WR) ? best_load : rd_data;
    unit_lt  = rd_data < best_load;
    unit_inc = (unit_a == LOAD_MAX) ? unit_a : unit_a + load_t'(1);
    unit_dec = (unit_a == '0) ? unit_a : unit_a - load_t'(1);
  end

  always_comb begin
    mem_req.rd_addr = '0;
    mem_req.we      = 1'b0;
    mem_req.wr_addr = best_idx;
    mem_req.wr_data = unit_inc;
    unique case (state)
      S_IDLE: begin
        if (in_ch.cmd == CMD_NEXT) begin
          mem_req.rd_addr = ptr_eff;
        end else if (in_ch.cmd == CMD_RELEASE) begin
          mem_req.rd_addr = in_ch.release_index;
        end
      end
      S_SCAN: begin
        mem_req.rd_addr = scan_cnt[IDX_W-1:0];
      end
      S_ACQ_WR: begin
        mem_req.we = 1'b1;
      end
      S_REL_RD: begin
        mem_req.we      = 1'b1;
        mem_req.wr_addr = cmp_idx;
        mem_req.wr_data = unit_dec;
      end
      S_NEXT_RD, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rr_ptr    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            n_q <= n_size;
            unique case (in_ch.cmd)
              CMD_NEXT: begin
                cmp_idx <= ptr_eff;
                state   <= S_NEXT_RD;
              end
              CMD_ACQUIRE: begin
                cmp_idx  <= '0;
                scan_cnt <= cnt_t'(1);
                state    <= S_SCAN;
              end
              CMD_RELEASE: begin
                cmp_idx <= in_ch.release_index;
                if (cnt_t'(in_ch.release_index) >= n_size) begin
                  res_index <= in_ch.release_index;
                  res_load  <= '0;
                  res_ign   <= 1'b1;
                  state     <= S_DONE;
                end else begin
                  state <= S_REL_RD;
                end
              end
              default: begin
                res_index <= '0;
                res_load  <= '0;
                res_ign   <= 1'b0;
                state     <= S_DONE;
              end
            endcase
          end
        end
        S_NEXT_RD: begin
          res_index <= cmp_idx;
          res_load  <= rd_data;
          res_ign   <= 1'b0;
          rr_ptr    <= (ptr_inc >= n_q) ? '0 : ptr_inc[IDX_W-1:0];
          state     <= S_DONE;
        end
        S_SCAN: begin
          // rd_data belongs to slot cmp_idx; strict less keeps the lowest index
          if (cmp_idx == '0 || unit_lt) begin
            best_idx  <= cmp_idx;
            best_load <= rd_data;
          end
          if (scan_cnt < n_q) begin
            cmp_idx  <= scan_cnt[IDX_W-1:0];
            scan_cnt <= scan_cnt + cnt_t'(1);
          end else begin
            state <= S_ACQ_WR;
          end
        end
        S_ACQ_WR: begin
          res_index <= best_idx;
          res_load  <= unit_inc;
          res_ign   <= 1'b0;
          state     <= S_DONE;
        end
        S_REL_RD: begin
          res_index <= cmp_idx;
          res_load  <= unit_dec;
          res_ign   <= 1'b0;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_index <= res_index;
      out_load  <= res_load;
      out_ign   <= res_ign;
    end
  end

  assign in_ch.ready         = (state == S_IDLE);
  assign out_ch.valid        = out_valid;
  assign out_ch.chosen_index = out_index;
  assign out_ch.chosen_load  = out_load;
  assign out_ch.ignored      = out_ign;

  a_ignored_zero_load: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ign |-> out_load == '0)
    else $error("ignored release reports a nonzero load");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("accepted command did not start the sequencer");

  a_write_only_busy: assert property (@(posedge clk) disable iff (rst)
    mem_req.we |-> (state == S_ACQ_WR || state == S_REL_RD))
    else $error("load memory written outside an update step");

  a_scan_bounded: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> scan_cnt <= n_q && cnt_t'(cmp_idx) < n_q)
    else $error("scan ran past the pool");

  a_ptr_in_pool: assert property (@(posedge clk) disable iff (rst)
    state == S_NEXT_RD |=> cnt_t'(rr_ptr) < n_q)
    else $error("round-robin pointer left outside the pool");

endmodule
`default_nettype wire

FILE: tb/least_loaded_slot_selector_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// least_loaded_slot_selector_top_tb
// Self-checking bench for the worker-slot dispatcher. A directed table runs
// first, then random commands run under three idling mixes with pool size
// changes in between.
// Every result transaction is checked against a behavioral model of the
// slot loads and the round-robin pointer, or against a directed row's value.
// ---------------------------------------------------------------------------
module least_loaded_slot_selector_top_tb
  import llss_pkg::*;
();

  localparam cmd_t   CMD_UNUSED    = 2'd3;
  localparam int     CLK_HALF      = 5;
  localparam int     RESET_CYCLES  = 9;
  localparam longint CYCLE_LIMIT   = 2000000;
  localparam int     RANDOM_ITEMS  = 1900;
  localparam int     SEGMENT_ITEMS = 50;
  localparam int     HOLD_CYCLES   = 300;
  localparam int     DRAIN_CYCLES  = 30;
  localparam int     REPORT_MAX    = 10;

  typedef struct packed {
    idx_t  index;
    load_t load;
    logic  ignored;
  } pick_t;

  typedef enum logic {ROW_CMD, ROW_POOL} row_kind_t;

  typedef struct {
    row_kind_t kind;
    cmd_t      cmd;
    idx_t      rel;
    pool_t     pool;
    bit        typed;
    pick_t     want;
  } row_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  cfg_we;
  pool_t cfg_wdata;

  llss_in_if  in_ch ();
  llss_out_if out_ch ();

  least_loaded_slot_selector_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #CLK_HALF clk = ~clk;

  // model state
  load_t slot_load_m [MAX_SLOTS];
  idx_t  rr_ptr_m;
  pool_t pool_m;

  pick_t pending [$];
  row_t  dir_rows [$];

  int     errors = 0;
  int     src_idle_pct = 0;
  int     snk_idle_pct = 0;
  bit     hold_req = 1'b0;
  bit     hold_done = 1'b0;
  int     hold_left = 0;
  longint cycle_count = 0;
  int     n_next = 0;
  int     n_acq = 0;
  int     n_rel = 0;
  int     n_ign = 0;
  int     n_unused = 0;
  int     n_sat = 0;
  int     n_pool_writes = 0;

  function automatic int pool_slots();
    if (pool_m == '0) return 1;
    if (int'(pool_m) > MAX_SLOTS) return MAX_SLOTS;
    return int'(pool_m);
  endfunction

  // applies one command to the model and returns the result it produces
  function automatic pick_t dispatch(input cmd_t c, input idx_t rel);
    pick_t r;
    int    n;
    int    p;
    int    best;
    int    i;
    n = pool_slots();
    r = '0;
    case (c)
      CMD_NEXT: begin
        // a pointer left past a shrunk pool restarts at slot 0
        p = (int'(rr_ptr_m) >= n) ? 0 : int'(rr_ptr_m);
        r.index = idx_t'(p);
        r.load = slot_load_m[p];
        rr_ptr_m = (p + 1 >= n) ? '0 : idx_t'(p + 1);
        n_next++;
      end
      CMD_ACQUIRE: begin
        best = 0;
        for (i = 1; i < n; i++) begin
          if (slot_load_m[i] < slot_load_m[best]) best = i;
        end
        if (slot_load_m[best] == LOAD_MAX) begin
          n_sat++;
        end else begin
          slot_load_m[best] = slot_load_m[best] + 1'b1;
        end
        r.index = idx_t'(best);
        r.load = slot_load_m[best];
        n_acq++;
      end
      CMD_RELEASE: begin
        r.index = rel;
        if (int'(rel) < n) begin
          if (slot_load_m[rel] != '0) slot_load_m[rel] = slot_load_m[rel] - 1'b1;
          r.load = slot_load_m[rel];
        end else begin
          r.ignored = 1'b1;
          n_ign++;
        end
        n_rel++;
      end
      default: begin
        n_unused++;
      end
    endcase
    return r;
  endfunction

  function automatic void flag(input string what);
    errors++;
    if (errors <= REPORT_MAX) $display("%s", what);
  endfunction

  function automatic void add_cmd(input cmd_t c, input idx_t rel, input bit typed,
                                  input idx_t w_idx, input load_t w_load,
                                  input logic w_ign);
    row_t r;
    r.kind = ROW_CMD;
    r.cmd = c;
    r.rel = rel;
    r.pool = '0;
    r.typed = typed;
    r.want = '{index: w_idx, load: w_load, ignored: w_ign};
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic void add_pool(input pool_t v);
    row_t r;
    r.kind = ROW_POOL;
    r.cmd = CMD_NEXT;
    r.rel = '0;
    r.pool = v;
    r.typed = 1'b0;
    r.want = '0;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  // offers one command and waits for its transaction; valid stays high after
  task automatic offer(input cmd_t c, input idx_t rel, input bit typed, input pick_t want);
    pick_t got;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= c;
    in_ch.release_index <= rel;
    do @(posedge clk); while (!in_ch.ready);
    got = dispatch(c, rel);
    pending.insert(pending.size(), typed ? want : got);
  endtask

  // pool size is only changed once every result has come back
  task automatic set_pool(input pool_t v);
    in_ch.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    pool_m = v;
    n_pool_writes++;
  endtask

  task automatic random_cmd();
    int   r;
    cmd_t c;
    idx_t rel;
    r = $urandom_range(99);
    if (r < 20) c = CMD_NEXT;
    else if (r < 60) c = CMD_ACQUIRE;
    else if (r < 95) c = CMD_RELEASE;
    else c = CMD_UNUSED;
    // mostly releases inside the pool so loads come back down
    if ($urandom_range(99) < 80) rel = idx_t'($urandom_range(pool_slots() - 1));
    else rel = idx_t'($urandom_range(15));
    offer(c, rel, 1'b0, '0);
  endtask

  function automatic pool_t random_pool();
    case ($urandom_range(9))
      0: return pool_t'(0);
      1: return pool_t'(1);
      2: return pool_t'(MAX_SLOTS);
      3: return pool_t'(31);
      4: return pool_t'($urandom_range(31));
      default: return pool_t'($urandom_range(2, 8));
    endcase
  endfunction

  // result side: random ready, one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending.size() == 0) begin
          flag($sformatf("unexpected result: idx %0d load %0d ign %0d",
                         out_ch.chosen_index, out_ch.chosen_load, out_ch.ignored));
        end else begin
          if (out_ch.chosen_index !== pending[0].index ||
              out_ch.chosen_load !== pending[0].load ||
              out_ch.ignored !== pending[0].ignored) begin
            flag($sformatf("mismatch: expected idx %0d load %0d ign %0d, got idx %0d load %0d ign %0d",
                           pending[0].index, pending[0].load, pending[0].ignored,
                           out_ch.chosen_index, out_ch.chosen_load, out_ch.ignored));
          end
          void'(pending.pop_front());
        end
      end
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending.size());
      $display("[least_loaded_slot_selector_top] ERROR");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_NEXT;
    in_ch.release_index = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    for (int i = 0; i < MAX_SLOTS; i++) slot_load_m[i] = '0;
    rr_ptr_m = '0;
    pool_m = pool_t'(1);

    // after reset: one slot, all loads zero
    add_cmd(CMD_NEXT,    4'd0,  1'b1, 4'd0,  16'd0, 1'b0);
    add_cmd(CMD_ACQUIRE, 4'd15, 1'b1, 4'd0,  16'd1, 1'b0);
    add_cmd(CMD_RELEASE, 4'd0,  1'b1, 4'd0,  16'd0, 1'b0);
    // release of an empty slot stays at zero
    add_cmd(CMD_RELEASE, 4'd0,  1'b1, 4'd0,  16'd0, 1'b0);
    // release outside the pool is echoed and flagged
    add_cmd(CMD_RELEASE, 4'd15, 1'b1, 4'd15, 16'd0, 1'b1);
    add_cmd(CMD_UNUSED,  4'd15, 1'b1, 4'd0,  16'd0, 1'b0);
    // zero pool behaves as one slot
    add_pool(5'd0);
    add_cmd(CMD_NEXT,    4'd0,  1'b1, 4'd0,  16'd0, 1'b0);
    add_cmd(CMD_RELEASE, 4'd1,  1'b1, 4'd1,  16'd0, 1'b1);
    add_pool(5'd16);
    add_cmd(CMD_ACQUIRE, 4'd0,  1'b1, 4'd0,  16'd1, 1'b0);
    add_cmd(CMD_ACQUIRE, 4'd0,  1'b1, 4'd1,  16'd1, 1'b0);
    add_cmd(CMD_ACQUIRE, 4'd0,  1'b1, 4'd2,  16'd1, 1'b0);
    add_cmd(CMD_NEXT,    4'd5,  1'b0, '0, '0, 1'b0);
    add_cmd(CMD_NEXT,    4'd10, 1'b0, '0, '0, 1'b0);
    add_cmd(CMD_RELEASE, 4'd15, 1'b1, 4'd15, 16'd0, 1'b0);
    add_cmd(CMD_RELEASE, 4'd1,  1'b0, '0, '0, 1'b0);
    // sizes above the table saturate
    add_pool(5'd31);
    add_cmd(CMD_ACQUIRE, 4'd10, 1'b0, '0, '0, 1'b0);
    add_cmd(CMD_NEXT,    4'd0,  1'b0, '0, '0, 1'b0);
    add_cmd(CMD_NEXT,    4'd0,  1'b0, '0, '0, 1'b0);
    // pointer now sits past the shrunk pool
    add_pool(5'd2);
    add_cmd(CMD_NEXT,    4'd0,  1'b0, '0, '0, 1'b0);
    add_cmd(CMD_ACQUIRE, 4'd0,  1'b0, '0, '0, 1'b0);
    // growing again reuses the loads kept beyond the old pool
    add_pool(5'd5);
    add_cmd(CMD_ACQUIRE, 4'd0,  1'b0, '0, '0, 1'b0);
    add_cmd(CMD_NEXT,    4'd0,  1'b0, '0, '0, 1'b0);
    add_cmd(CMD_UNUSED,  4'd5,  1'b1, 4'd0,  16'd0, 1'b0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    src_idle_pct = 34;
    snk_idle_pct <= 77;
    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_POOL) begin
        set_pool(dir_rows[k].pool);
      end else begin
        offer(dir_rows[k].cmd, dir_rows[k].rel, dir_rows[k].typed, dir_rows[k].want);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 34;
          snk_idle_pct <= 77;
        end
        1: begin
          src_idle_pct = 77;
          snk_idle_pct <= 34;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct <= 0;
        end
      endcase
      for (int seg = 0; seg < RANDOM_ITEMS / 3 / SEGMENT_ITEMS + 1; seg++) begin
        set_pool(random_pool());
        // long result stall while commands keep coming
        if (phase == 2 && seg == 0) hold_req <= 1'b1;
        repeat (SEGMENT_ITEMS) random_cmd();
      end
    end

    in_ch.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("commands: %0d next, %0d acquire, %0d release (%0d outside the pool), %0d unused",
             n_next, n_acq, n_rel, n_ign, n_unused);
    $display("pool writes %0d, acquires on a full slot %0d, mismatches %0d",
             n_pool_writes, n_sat, errors);
    if (errors == 0) begin
      $display("[least_loaded_slot_selector_top] OK");
    end else begin
      $display("[least_loaded_slot_selector_top] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/llss_pkg.sv
hw/rtl/llss_in_if.sv
hw/rtl/llss_out_if.sv
hw/rtl/llss_load_mem.sv
hw/rtl/llss_ctrl.sv
hw/rtl/least_loaded_slot_selector_top.sv
tb/least_loaded_slot_selector_top_tb.sv
